// File: rtl/core/lossless_pixel_predictor_residual_top_assert.svh
// ----------------------------------------------------------------------------
// lossless pixel predictor residual: assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef LOSSLESS_PIXEL_PREDICTOR_RESIDUAL_TOP_ASSERT_SVH
`define LOSSLESS_PIXEL_PREDICTOR_RESIDUAL_TOP_ASSERT_SVH

// general property, sampled on clk, off while rst_n is low
`define LPPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a signal of the result channel holds while the word is stalled
`define LPPR_ASSERT_HOLD(lbl, sig, msg) \
  `LPPR_ASSERT(lbl, (out_valid && !out_ready) |=> $stable(sig), msg)

`endif

// File: rtl/core/lppr_pkg.sv
// ----------------------------------------------------------------------------
// lppr_pkg
// constants and codes of the lossless pixel predictor residual block
// ----------------------------------------------------------------------------
package lppr_pkg;

  localparam int LPPR_SAMPLE_W      = 8;
  localparam int LPPR_RESIDUAL_W    = 10;
  localparam int LPPR_MODE_W        = 4;
  localparam int LPPR_SIZE_W        = 12;
  localparam int LPPR_CFG_IDX_W     = 2;
  localparam int LPPR_MAX_WIDTH_DEF = 2048;
  localparam int LPPR_MAX_HEIGHT    = 2048;

  // predictor select codes; all other codes predict zero
  typedef enum logic [LPPR_MODE_W-1:0] {
    MODE_LEFT  = 4'd1,
    MODE_UP    = 4'd2,
    MODE_DIAG  = 4'd3,
    MODE_PLANE = 4'd4,
    MODE_LHALF = 4'd5,
    MODE_UHALF = 4'd6,
    MODE_AVG   = 4'd7,
    MODE_MED   = 4'd8
  } lppr_mode_t;

  // configuration register indexes
  typedef enum logic [LPPR_CFG_IDX_W-1:0] {
    CFG_PRED_MODE    = 2'd0,
    CFG_PLANE_WIDTH  = 2'd1,
    CFG_PLANE_HEIGHT = 2'd2
  } lppr_cfg_idx_t;

  localparam logic [LPPR_MODE_W-1:0] LPPR_MODE_RST   = MODE_MED;
  localparam logic [LPPR_SIZE_W-1:0] LPPR_WIDTH_RST  = 12'd640;
  localparam logic [LPPR_SIZE_W-1:0] LPPR_HEIGHT_RST = 12'd480;

endpackage

// File: rtl/core/lossless_pixel_predictor_residual_top.sv
// ----------------------------------------------------------------------------
// lossless_pixel_predictor_residual_top
// prediction residual of 8-bit raster samples, lossless jpeg modes and med
// ----------------------------------------------------------------------------
// usage
//   in_*   : one sample word per handshake, raster order within a plane
//   out_*  : one residual word per sample, same order, plane_end marks the
//            last sample of the plane
//   cfg_*  : register writes (mode, width, height), only while idle
// path: an accepted sample waits in the input stage, then moves to the output
//   register; throughput: one word per cycle while out_ready holds; the line
//   buffer ram is read once at the accept edge and written once when the word
//   moves to the output register, so one read and one write port sustain that rate
// stall: the output register holds its word; the input stage still takes one
//   more word, then in_ready drops until out_ready returns
// reset: counters, left and upper-left samples and registers go to their
//   defaults, pipeline valids clear; the line buffer is not cleared since
//   row zero forces the upper neighbours to zero
// ----------------------------------------------------------------------------
module lossless_pixel_predictor_residual_top
  import lppr_pkg::*;
#(
  parameter int MAX_WIDTH = LPPR_MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [LPPR_SAMPLE_W-1:0]          in_sample_value,
  // residual channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [LPPR_RESIDUAL_W-1:0] out_residual,
  output logic                              out_plane_end,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [LPPR_CFG_IDX_W-1:0]         cfg_index,
  input  logic [LPPR_SIZE_W-1:0]            cfg_wr_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMPW  = (CW + 1 > LPPR_SIZE_W) ? CW + 1 : LPPR_SIZE_W;
  localparam int RW    = $clog2(LPPR_MAX_HEIGHT);
  localparam int HCMPW = (RW + 1 > LPPR_SIZE_W) ? RW + 1 : LPPR_SIZE_W;
  localparam int PW    = LPPR_SAMPLE_W + 3;  // signed prediction width

  // truncate-toward-zero halving
  function automatic logic signed [PW-1:0] half_tz(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + {{(PW-1){1'b0}}, v[PW-1]};
    return t >>> 1;
  endfunction

  function automatic logic signed [PW-1:0] predict(
    input logic [LPPR_MODE_W-1:0] mode,
    input logic signed [PW-1:0]   a,
    input logic signed [PW-1:0]   b,
    input logic signed [PW-1:0]   c
  );
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] p;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (mode)
      MODE_LEFT:  p = a;
      MODE_UP:    p = b;
      MODE_DIAG:  p = c;
      MODE_PLANE: p = a + b - c;
      MODE_LHALF: p = a + half_tz(b - c);
      MODE_UHALF: p = b + half_tz(a - c);
      MODE_AVG:   p = half_tz(a + b);
      MODE_MED: begin
        if (c <= lo) begin
          p = hi;
        end else if (c >= hi) begin
          p = lo;
        end else begin
          p = a + b - c;
        end
      end
      default:    p = '0;
    endcase
    return p;
  endfunction

  // configuration registers
  logic [LPPR_MODE_W-1:0] pred_mode_r;
  logic [LPPR_SIZE_W-1:0] plane_width_r;
  logic [LPPR_SIZE_W-1:0] plane_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_mode_r    <= LPPR_MODE_RST;
      plane_width_r  <= LPPR_WIDTH_RST;
      plane_height_r <= LPPR_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRED_MODE:    pred_mode_r    <= cfg_wr_data[LPPR_MODE_W-1:0];
        CFG_PLANE_WIDTH:  plane_width_r  <= cfg_wr_data;
        CFG_PLANE_HEIGHT: plane_height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic accept;

  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign accept   = in_valid & in_ready;

  // position counters, for the next word to be accepted
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CMPW-1:0]  col_inc;
  logic [CMPW-1:0]  width_ext;
  logic [HCMPW-1:0] row_inc;
  logic [HCMPW-1:0] height_ext;
  logic             row_end;
  logic             plane_end;

  assign col_inc    = CMPW'(col_r) + CMPW'(1);
  assign width_ext  = CMPW'(plane_width_r);
  assign row_inc    = HCMPW'(row_r) + HCMPW'(1);
  assign height_ext = HCMPW'(plane_height_r);

  // zero size acts as one, oversize acts as the maximum
  always_comb begin
    if (plane_width_r == '0) begin
      row_end = 1'b1;
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      row_end = (col_inc >= CMPW'(MAX_WIDTH));
    end else begin
      row_end = (col_inc >= width_ext);
    end

    if (plane_height_r == '0) begin
      plane_end = row_end;
    end else if (height_ext > HCMPW'(LPPR_MAX_HEIGHT)) begin
      plane_end = row_end & (row_inc >= HCMPW'(LPPR_MAX_HEIGHT));
    end else begin
      plane_end = row_end & (row_inc >= height_ext);
    end

    if (row_end) begin
      col_nxt = '0;
      row_nxt = plane_end ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input stage: sample and its position flags
  logic [LPPR_SAMPLE_W-1:0] s1_x_r;
  logic [CW-1:0]            s1_col_r;
  logic                     s1_col_nz_r;
  logic                     s1_row_nz_r;
  logic                     s1_plane_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r         <= in_sample_value;
      s1_col_r       <= col_r;
      s1_col_nz_r    <= (col_r != '0);
      s1_row_nz_r    <= (row_r != '0);
      s1_plane_end_r <= plane_end;
    end
  end

  // line buffer: read at accept, written when the word leaves the input stage
  logic [LPPR_SAMPLE_W-1:0] ram_rdata;
  logic                     byp_r;
  logic [LPPR_SAMPLE_W-1:0] byp_data_r;
  logic [LPPR_SAMPLE_W-1:0] above;

  lppr_ram #(
    .WIDTH (LPPR_SAMPLE_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_x_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // read and write of the same column at one edge (one-sample rows):
  // forward the word being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (accept) begin
      byp_r <= s1_adv & (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= s1_x_r;
    end
  end

  assign above = byp_r ? byp_data_r : ram_rdata;

  // neighbour registers, updated as each word moves on
  logic [LPPR_SAMPLE_W-1:0] left_r;
  logic [LPPR_SAMPLE_W-1:0] upper_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      upper_left_r <= '0;
    end else if (s1_adv) begin
      left_r       <= s1_x_r;
      upper_left_r <= s1_row_nz_r ? above : '0;
    end
  end

  // prediction and residual
  logic signed [PW-1:0] nb_a, nb_b, nb_c;
  logic signed [PW-1:0] pred;
  logic signed [PW-1:0] resid;

  assign nb_a  = s1_col_nz_r ? PW'(left_r) : '0;
  assign nb_b  = s1_row_nz_r ? PW'(above) : '0;
  assign nb_c  = (s1_row_nz_r & s1_col_nz_r) ? PW'(upper_left_r) : '0;
  assign pred  = predict(pred_mode_r, nb_a, nb_b, nb_c);
  assign resid = PW'(s1_x_r) - pred;

  // output register
  logic signed [LPPR_RESIDUAL_W-1:0] out_residual_r;
  logic                              out_plane_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_residual_r  <= resid[LPPR_RESIDUAL_W-1:0];
      out_plane_end_r <= s1_plane_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_residual  = out_residual_r;
  assign out_plane_end = out_plane_end_r;

endmodule

// File: rtl/core/lppr_ram.sv
// ----------------------------------------------------------------------------
// lppr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lppr_ram
  import lppr_pkg::*;
#(
  parameter int WIDTH = LPPR_SAMPLE_W,
  parameter int DEPTH = LPPR_MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lppr_chk.sv
// ----------------------------------------------------------------------------
// lppr_chk
// port-level checks of the lossless pixel predictor residual block
// ----------------------------------------------------------------------------
`include "lossless_pixel_predictor_residual_top_assert.svh"

module lppr_chk
  import lppr_pkg::*;
(
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [LPPR_RESIDUAL_W-1:0] out_residual,
  input logic                              out_plane_end
);

  // a stalled word stays put
  `LPPR_ASSERT_HOLD(a_out_valid_hold, out_valid, "out_valid dropped while stalled")
  `LPPR_ASSERT_HOLD(a_out_payload_hold, {out_residual, out_plane_end}, "word changed while stalled")

  // a rising out_valid follows a taken sample, passed on through the input stage and the output register
  `LPPR_ASSERT(a_out_from_in, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "word without sample")

  // residual of 8-bit samples stays within -510..510
  `LPPR_ASSERT(a_resid_range, out_valid |-> (out_residual != 10'sh200 && out_residual != 10'sh201 && out_residual != 10'sh1FF), "residual out of range")

endmodule

bind lossless_pixel_predictor_residual_top lppr_chk u_lppr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_residual  (out_residual),
  .out_plane_end (out_plane_end)
);

// File: bench/lossless_pixel_predictor_residual_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lossless_pixel_predictor_residual_top_tb
// self-checking bench: raster samples go in on a valid/ready channel, every
// residual word is checked against a cycle-free predictor of the line buffer,
// neighbour selection, predictor modes and plane counters
// ----------------------------------------------------------------------------
module lossless_pixel_predictor_residual_top_tb;
  import lppr_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 1440;
  localparam int HOLD_CYCLES  = 60;
  localparam int CLAMP_RUN    = 40;

  // predictor codes outside the enum, all of them predict zero
  localparam logic [LPPR_MODE_W-1:0] MODE_NONE      = 4'd0;
  localparam logic [LPPR_MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [LPPR_MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  // two-wide rows: full swings give the largest residuals of either sign
  localparam logic [LPPR_SAMPLE_W-1:0] SWING_ROWS [6] =
    '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
  // median rows: upper-left above both, then upper-left between them
  localparam logic [LPPR_SAMPLE_W-1:0] MEDIAN_ROWS [4] =
    '{8'd40, 8'd30, 8'd70, 8'd200};
  localparam logic [LPPR_MODE_W-1:0] ROW_MODES [7] =
    '{MODE_LEFT, MODE_UP, MODE_DIAG, MODE_LHALF, MODE_UHALF, MODE_AVG, MODE_UNUSED_HI};

  typedef struct packed {
    logic signed [LPPR_RESIDUAL_W-1:0] residual;
    logic                              plane_end;
  } residual_word_t;

  // --------------------------------------------------------------------------
  // residual predictor and store of expected words
  // --------------------------------------------------------------------------
  class residual_scoreboard;
    logic [LPPR_SAMPLE_W-1:0] line_buf [LPPR_MAX_WIDTH_DEF];
    int unsigned              filled;
    logic [LPPR_SAMPLE_W-1:0] left_px;
    logic [LPPR_SAMPLE_W-1:0] upleft_px;
    int unsigned              col_cnt;
    int unsigned              row_cnt;
    logic [LPPR_MODE_W-1:0]   mode;
    logic [LPPR_SIZE_W-1:0]   width;
    logic [LPPR_SIZE_W-1:0]   height;
    residual_word_t           expected_q [$];
    int                       errors;
    int                       words_seen;

    function new();
      foreach (line_buf[i]) line_buf[i] = '0;
      filled     = 0;
      left_px    = '0;
      upleft_px  = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mode       = LPPR_MODE_RST;
      width      = LPPR_WIDTH_RST;
      height     = LPPR_HEIGHT_RST;
      errors     = 0;
      words_seen = 0;
    endfunction

    function int unsigned eff_size(logic [LPPR_SIZE_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int predicted(int a, int b, int c);
      int lo, hi, grad;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case (mode)
        MODE_LEFT:  return a;
        MODE_UP:    return b;
        MODE_DIAG:  return c;
        MODE_PLANE: return a + b - c;
        MODE_LHALF: return a + (b - c) / 2;
        MODE_UHALF: return b + (a - c) / 2;
        MODE_AVG:   return (a + b) / 2;
        MODE_MED: begin
          grad = a + b - c;
          if (c >= hi) grad = lo;
          if (c <= lo) grad = hi;
          return grad;
        end
        default:    return 0;
      endcase
    endfunction

    function void note_config(lppr_cfg_idx_t idx, logic [LPPR_SIZE_W-1:0] data);
      case (idx)
        CFG_PRED_MODE:    mode = data[LPPR_MODE_W-1:0];
        CFG_PLANE_WIDTH:  width = data;
        CFG_PLANE_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    // a wider row past row zero may only reach buffer entries already filled
    function logic [LPPR_SIZE_W-1:0] fit_width(logic [LPPR_SIZE_W-1:0] w);
      if (row_cnt == 0 || eff_size(w, LPPR_MAX_WIDTH_DEF) <= filled) return w;
      return LPPR_SIZE_W'(filled);
    endfunction

    function void note_sample(logic [LPPR_SAMPLE_W-1:0] x);
      int unsigned              w_eff, h_eff, col;
      int                       a, b, c, res;
      logic [LPPR_SAMPLE_W-1:0] above;
      bit                       row_end, ends_plane;
      residual_word_t           word;
      w_eff = eff_size(width, LPPR_MAX_WIDTH_DEF);
      h_eff = eff_size(height, LPPR_MAX_HEIGHT);
      col   = col_cnt % LPPR_MAX_WIDTH_DEF;
      above = line_buf[col];
      a = (col > 0) ? int'(left_px) : 0;
      b = (row_cnt > 0) ? int'(above) : 0;
      c = (row_cnt > 0 && col > 0) ? int'(upleft_px) : 0;
      res = int'(x) - predicted(a, b, c);

      line_buf[col] = x;
      if (col + 1 > filled) filled = col + 1;
      left_px   = x;
      upleft_px = (row_cnt > 0) ? above : '0;

      row_end    = (col + 1 >= w_eff);
      ends_plane = row_end && (row_cnt + 1 >= h_eff);
      if (row_end) begin
        col_cnt = 0;
        row_cnt = ends_plane ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col + 1;
      end

      word.residual  = res[LPPR_RESIDUAL_W-1:0];
      word.plane_end = ends_plane;
      expected_q.push_back(word);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at word %0d: %s", words_seen, what);
      errors++;
    endtask

    task check_word(logic signed [LPPR_RESIDUAL_W-1:0] residual, logic plane_end);
      residual_word_t want;
      words_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("residual %0d arrived with nothing expected", residual));
        return;
      end
      want = expected_q.pop_front();
      if (residual !== want.residual)
        report_mismatch($sformatf("residual %0d, expected %0d", residual, want.residual));
      if (plane_end !== want.plane_end)
        report_mismatch($sformatf("plane_end %b, expected %b", plane_end, want.plane_end));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [LPPR_SAMPLE_W-1:0]          in_sample_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [LPPR_RESIDUAL_W-1:0] out_residual;
  logic                              out_plane_end;
  logic                              cfg_wr_en = 1'b0;
  lppr_cfg_idx_t                     cfg_index = CFG_PRED_MODE;
  logic [LPPR_SIZE_W-1:0]            cfg_wr_data = '0;

  residual_scoreboard sb = new();

  // idle rates in percent, set per phase by the main sequence
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // long receiver hold-offs: main asks, the receiver process counts them out
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [LPPR_SAMPLE_W-1:0] last_sample = '0;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  lossless_pixel_predictor_residual_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_residual    (out_residual),
    .out_plane_end   (out_plane_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data)
  );

  // receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // both channels sampled at the edge, so values are the ones the block saw
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_sample_value);
      if (out_valid && out_ready) sb.check_word(out_residual, out_plane_end);
    end
  end

  // cycles in a row with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // random image content, with smooth steps and the sample extremes mixed in
  function automatic logic [LPPR_SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return last_sample + 8'($urandom_range(6)) - 8'd3;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [LPPR_MODE_W-1:0] pick_mode();
    if ($urandom_range(9) != 0) return 4'($urandom_range(MODE_LEFT, MODE_MED));
    if ($urandom_range(1) == 0) return MODE_NONE;
    return 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
  endfunction

  // small sizes keep planes short; zero and oversize values now and then
  function automatic logic [LPPR_SIZE_W-1:0] pick_size(int unsigned top);
    case ($urandom_range(15))
      0:       return '0;
      1:       return 12'($urandom_range(top + 1, 4095));
      2:       return 12'($urandom_range(25, 300));
      default: return 12'($urandom_range(1, 24));
    endcase
  endfunction

  // one sample word, with a random gap first; valid stays up until accepted
  task automatic send_sample(input logic [LPPR_SAMPLE_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    last_sample = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender goes quiet until every expected residual has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // all three registers in back-to-back cycles, only with the block idle
  task automatic set_config(input logic [LPPR_MODE_W-1:0] pred,
                            input logic [LPPR_SIZE_W-1:0] w,
                            input logic [LPPR_SIZE_W-1:0] h);
    logic [LPPR_SIZE_W-1:0] w_safe;
    drain_results();
    // a margin so that the block is surely idle before the writes
    repeat (2) @(posedge clk);
    w_safe = sb.fit_width(w);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_PRED_MODE;
    cfg_wr_data <= {8'h00, pred};
    @(posedge clk);
    cfg_index   <= CFG_PLANE_WIDTH;
    cfg_wr_data <= w_safe;
    @(posedge clk);
    cfg_index   <= CFG_PLANE_HEIGHT;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.note_config(CFG_PRED_MODE, {8'h00, pred});
    sb.note_config(CFG_PLANE_WIDTH, w_safe);
    sb.note_config(CFG_PLANE_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 13;
    rx_idle_pct = 64;

    // reset defaults: median mode, 640 by 480, first words of row zero
    send_sample(8'h00);
    send_sample(8'hFF);
    // shrink to one by one mid-plane: column already past the width ends it
    set_config(MODE_MED, 12'd1, 12'd1);
    send_sample(8'h5A);

    // two-wide rows, height above the limit so the plane runs on
    set_config(MODE_PLANE, 12'd2, 12'hFFF);
    foreach (SWING_ROWS[i]) send_sample(SWING_ROWS[i]);
    set_config(MODE_MED, 12'd2, 12'hFFF);
    foreach (MEDIAN_ROWS[i]) send_sample(MEDIAN_ROWS[i]);
    // one row per remaining mode, odd differences can hit the truncating halves
    foreach (ROW_MODES[i]) begin
      set_config(ROW_MODES[i], 12'd2, 12'hFFF);
      send_sample(pick_sample());
      send_sample(pick_sample());
    end

    // zero width and height act as one: the next word closes the plane
    set_config(MODE_NONE, 12'd0, 12'd0);
    send_sample(8'hFF);
    // oversize width acts as the buffer size; the next size change cuts the
    // row, its column already past the new width
    set_config(MODE_MED, 12'hFFF, 12'd1);
    repeat (CLAMP_RUN) send_sample(pick_sample());
    // oversize height acts as the maximum, a column one sample wide
    set_config(MODE_AVG, 12'd1, 12'hFFF);
    repeat (CLAMP_RUN) send_sample(pick_sample());

    // random phases under three idle patterns, the last with none at all
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin tx_idle_pct = 13; rx_idle_pct = 64; end
        1: begin tx_idle_pct = 64; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < RANDOM_WORDS / 3) begin
        set_config(pick_mode(), pick_size(LPPR_MAX_WIDTH_DEF), pick_size(LPPR_MAX_HEIGHT));
        burst = $urandom_range(40, 120);
        // receiver stops for a while so the pipe fills and in_ready drops
        if (regime == 0 && sent == 0) hold_requests++;
        for (int k = 0; k < burst; k++) begin
          // sender waits for the pipe to empty in the middle of a plane
          if (regime == 1 && sent == 0 && k == burst / 2) drain_results();
          send_sample(pick_sample());
        end
        sent += burst;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
